// ===== rtl/run_boundary_prefix_sum_assert.svh =====
// Assertion macros used by the run boundary prefix sum checker.
`ifndef RUN_BOUNDARY_PREFIX_SUM_ASSERT_SVH
`define RUN_BOUNDARY_PREFIX_SUM_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define RBPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("run_boundary_prefix_sum: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define RBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("run_boundary_prefix_sum: next-cycle check failed");

`endif

// ===== rtl/rbps_pkg.sv =====
// Shared types, sizes and helper functions of the run boundary prefix sum block.
`default_nettype none

package rbps_pkg;

   // Column counts and field widths.
   localparam int ADDR_COLS   = 4;
   localparam int AGG_COLS    = 4;
   localparam int ADDR_WIDTH  = 32;
   localparam int TOTAL_WIDTH = 64;
   localparam int VALUE_WIDTH = 32;

   // Configuration port.
   localparam int CSR_WIDTH       = 3;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADDR_COLS_USED = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AGG_COLS_USED  = 1'b1;
   localparam logic [CSR_WIDTH-1:0]       CSR_COLS_RESET     = 3'd1;

   // Queue between front and back.
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Result kinds an input word can cause, in emission order.
   localparam int KIND_COUNT    = 3;
   localparam int KIND_ZERO     = 0;
   localparam int KIND_BOUNDARY = 1;
   localparam int KIND_CLOSING  = 2;

   typedef logic [ADDR_WIDTH-1:0]  addr_type;
   typedef logic [TOTAL_WIDTH-1:0] total_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;

   // One input row.
   typedef struct packed {
      logic                         first_row;
      logic                         last_row;
      addr_type  [ADDR_COLS-1:0]    addr;
      value_type [AGG_COLS-1:0]     value;
   } row_type;

   // One classified row waiting for the back end.
   typedef struct packed {
      logic      [KIND_COUNT-1:0]   kinds;
      logic      [ADDR_COLS-1:0]    addr_used;
      addr_type  [ADDR_COLS-1:0]    addr;
      total_type [AGG_COLS-1:0]     total_before;
      total_type [AGG_COLS-1:0]     total_after;
   } entry_type;

   // One result word.
   typedef struct packed {
      addr_type  [ADDR_COLS-1:0]    addr;
      total_type [AGG_COLS-1:0]     total;
      logic                         final_entry;
   } result_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Columns in use for a column count register; zero acts as one, large values saturate.
   function automatic logic [ADDR_COLS-1:0] addr_use_mask(input logic [CSR_WIDTH-1:0] cols);
      logic [ADDR_COLS-1:0] mask;
      for (int i = 0; i < ADDR_COLS; i++) begin
         mask[i] = (i == 0) || (int'(cols) > i);
      end
      return mask;
   endfunction

   function automatic logic [AGG_COLS-1:0] agg_use_mask(input logic [CSR_WIDTH-1:0] cols);
      logic [AGG_COLS-1:0] mask;
      for (int i = 0; i < AGG_COLS; i++) begin
         mask[i] = (i == 0) || (int'(cols) > i);
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rbps_front.sv =====
// Front end: takes rows, compares addresses, keeps running totals and queues the result kinds.
`default_nettype none

module rbps_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_en,
   input  wire logic [rbps_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [rbps_pkg::CSR_WIDTH-1:0]         csr_write_data,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire rbps_pkg::row_type                      req_row,
   input  wire rbps_pkg::q_status_type                 q_status,
   output logic                                        q_push,
   output rbps_pkg::entry_type                         q_entry
);
   import rbps_pkg::*;

   logic [CSR_WIDTH-1:0]      addr_cols_ff;
   logic [CSR_WIDTH-1:0]      agg_cols_ff;
   addr_type  [ADDR_COLS-1:0] prev_addr_ff;
   addr_type  [ADDR_COLS-1:0] prev_addr_in;
   total_type [AGG_COLS-1:0]  total_ff;
   total_type [AGG_COLS-1:0]  total_in;

   logic [ADDR_COLS-1:0]      addr_used;
   logic [AGG_COLS-1:0]       agg_used;
   logic                      differs;
   addr_type  [ADDR_COLS-1:0] prev_eff;
   total_type [AGG_COLS-1:0]  total_before;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_cols_ff <= CSR_COLS_RESET;
         agg_cols_ff  <= CSR_COLS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ADDR_COLS_USED: addr_cols_ff <= csr_write_data;
            CSR_AGG_COLS_USED:  agg_cols_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign addr_used = addr_use_mask(addr_cols_ff);
   assign agg_used  = agg_use_mask(agg_cols_ff);
   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready;

   // A first row sees cleared state; compare used columns against it.
   always_comb begin
      differs = 1'b0;
      for (int i = 0; i < ADDR_COLS; i++) begin
         prev_eff[i] = req_row.first_row ? '0 : prev_addr_ff[i];
         if (addr_used[i] && (req_row.addr[i] != prev_eff[i])) begin
            differs = 1'b1;
         end
      end
      for (int i = 0; i < AGG_COLS; i++) begin
         total_before[i] = req_row.first_row ? '0 : total_ff[i];
      end
   end

   // Next state and the queued entry.
   always_comb begin
      for (int i = 0; i < ADDR_COLS; i++) begin
         prev_addr_in[i] = (differs && addr_used[i]) ? req_row.addr[i] : prev_eff[i];
         q_entry.addr[i] = addr_used[i] ? req_row.addr[i] : '0;
      end
      for (int i = 0; i < AGG_COLS; i++) begin
         total_in[i] = agg_used[i]
            ? total_before[i] + TOTAL_WIDTH'(req_row.value[i]) : total_before[i];
         q_entry.total_before[i] = agg_used[i] ? total_before[i] : '0;
         q_entry.total_after[i]  = agg_used[i] ? total_in[i] : '0;
      end
      q_entry.addr_used               = addr_used;
      q_entry.kinds[KIND_ZERO]        = req_row.first_row;
      q_entry.kinds[KIND_BOUNDARY]    = differs;
      q_entry.kinds[KIND_CLOSING]     = req_row.last_row;
   end

   // Previous address and running totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_addr_ff <= '0;
         total_ff     <= '0;
      end else if (q_push) begin
         prev_addr_ff <= prev_addr_in;
         total_ff     <= total_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rbps_queue.sv =====
// Short queue of classified rows between the front and back ends.
`default_nettype none

module rbps_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire rbps_pkg::entry_type   push_entry,
   input  wire logic                  pop,
   output rbps_pkg::entry_type        head,
   output rbps_pkg::q_status_type     status
);
   import rbps_pkg::*;

   entry_type                  slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_in;

   // Occupancy follows push and pop.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/rbps_back.sv =====
// Back end: walks the result kinds of the queue head and fills the output register.
`default_nettype none

module rbps_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rbps_pkg::entry_type   head,
   input  wire rbps_pkg::q_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rbps_pkg::result_type       rsp_result
);
   import rbps_pkg::*;

   logic [KIND_COUNT-1:0] done_ff;
   logic [KIND_COUNT-1:0] done_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   result_type            rsp_data_ff;
   result_type            rsp_data_in;

   logic [KIND_COUNT-1:0] pending;
   logic [KIND_COUNT-1:0] sel_mask;
   logic [KIND_COUNT-1:0] rest;
   logic                  load;
   logic                  emit;
   result_type            next_result;

   // Pick the earliest kind of the head not yet sent.
   assign pending  = q_status.empty ? '0 : (head.kinds & ~done_ff);
   assign sel_mask = pending & (~pending + KIND_COUNT'(1));
   assign rest     = pending & ~sel_mask;
   assign load     = !rsp_valid_ff || rsp_ready;
   assign emit     = load && (pending != '0);
   assign pop      = (!q_status.empty && (pending == '0)) || (emit && (rest == '0));

   // Build the selected result word.
   always_comb begin
      next_result = '0;
      if (sel_mask[KIND_BOUNDARY]) begin
         next_result.addr  = head.addr;
         next_result.total = head.total_before;
      end
      if (sel_mask[KIND_CLOSING]) begin
         for (int i = 0; i < ADDR_COLS; i++) begin
            next_result.addr[i] = head.addr_used[i] ? '1 : '0;
         end
         next_result.total       = head.total_after;
         next_result.final_entry = 1'b1;
      end
   end

   // Progress through the head and the output register.
   always_comb begin
      done_in = done_ff;
      if (pop) begin
         done_in = '0;
      end else if (emit) begin
         done_in = done_ff | sel_mask;
      end
      rsp_valid_in = load ? (pending != '0) : rsp_valid_ff;
      rsp_data_in  = emit ? next_result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/run_boundary_prefix_sum.sv =====
// Top level of the run boundary prefix sum block: front end, queue and back end.
//
// Rows of a table sorted by address enter on the req_ channel, one word per
// valid/ready handshake. Each row yields up to three words on the rsp_ channel,
// in order: an all-zero entry for a first row, a boundary entry when the used
// address columns change, and a closing entry flagged final_entry for a last
// row, all ones in the used address columns. The csr_ port sets how many address
// and aggregate columns are used; write it only while the block is idle.
// The first word of a row passes through the queue and the output register.
// Throughput: one row per cycle while each row yields at most one word and
// rsp_ready stays high; the back end sends a row's result words one at a time
// and drops a row that yields none, and the four-entry queue absorbs the difference.
// A stalled receiver holds the output register; the front keeps accepting
// until the queue is full, then drops req_ready.
// Reset empties the queue and output register, clears the previous address
// and running totals, and sets both column counts to one.
`default_nettype none

module run_boundary_prefix_sum (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_en,
   input  wire logic [rbps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [rbps_pkg::CSR_WIDTH-1:0]        csr_write_data,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_first_row,
   input  wire logic                                  req_last_row,
   input  wire logic [rbps_pkg::ADDR_WIDTH-1:0]       req_addr_0,
   input  wire logic [rbps_pkg::ADDR_WIDTH-1:0]       req_addr_1,
   input  wire logic [rbps_pkg::ADDR_WIDTH-1:0]       req_addr_2,
   input  wire logic [rbps_pkg::ADDR_WIDTH-1:0]       req_addr_3,
   input  wire logic [rbps_pkg::VALUE_WIDTH-1:0]      req_value_0,
   input  wire logic [rbps_pkg::VALUE_WIDTH-1:0]      req_value_1,
   input  wire logic [rbps_pkg::VALUE_WIDTH-1:0]      req_value_2,
   input  wire logic [rbps_pkg::VALUE_WIDTH-1:0]      req_value_3,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [rbps_pkg::ADDR_WIDTH-1:0]            rsp_out_addr_0,
   output logic [rbps_pkg::ADDR_WIDTH-1:0]            rsp_out_addr_1,
   output logic [rbps_pkg::ADDR_WIDTH-1:0]            rsp_out_addr_2,
   output logic [rbps_pkg::ADDR_WIDTH-1:0]            rsp_out_addr_3,
   output logic [rbps_pkg::TOTAL_WIDTH-1:0]           rsp_total_0,
   output logic [rbps_pkg::TOTAL_WIDTH-1:0]           rsp_total_1,
   output logic [rbps_pkg::TOTAL_WIDTH-1:0]           rsp_total_2,
   output logic [rbps_pkg::TOTAL_WIDTH-1:0]           rsp_total_3,
   output logic                                       rsp_final_entry
);
   import rbps_pkg::*;

   row_type      req_row;
   entry_type    q_entry;
   entry_type    q_head;
   q_status_type q_status;
   logic         q_push;
   logic         q_pop;
   result_type   rsp_result;

   // Gather the row fields.
   assign req_row.first_row = req_first_row;
   assign req_row.last_row  = req_last_row;
   assign req_row.addr[0]   = req_addr_0;
   assign req_row.addr[1]   = req_addr_1;
   assign req_row.addr[2]   = req_addr_2;
   assign req_row.addr[3]   = req_addr_3;
   assign req_row.value[0]  = req_value_0;
   assign req_row.value[1]  = req_value_1;
   assign req_row.value[2]  = req_value_2;
   assign req_row.value[3]  = req_value_3;

   rbps_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_row        (req_row),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   rbps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   rbps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .q_status   (q_status),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   // Spread the result word over the output ports.
   assign rsp_out_addr_0  = rsp_result.addr[0];
   assign rsp_out_addr_1  = rsp_result.addr[1];
   assign rsp_out_addr_2  = rsp_result.addr[2];
   assign rsp_out_addr_3  = rsp_result.addr[3];
   assign rsp_total_0     = rsp_result.total[0];
   assign rsp_total_1     = rsp_result.total[1];
   assign rsp_total_2     = rsp_result.total[2];
   assign rsp_total_3     = rsp_result.total[3];
   assign rsp_final_entry = rsp_result.final_entry;

endmodule

`default_nettype wire

// ===== rtl/rbps_checker.sv =====
// Port-level checker of the run boundary prefix sum block and its bind.
`default_nettype none

`include "run_boundary_prefix_sum_assert.svh"

module rbps_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_ready,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   input  wire logic [rbps_pkg::ADDR_WIDTH-1:0]       rsp_out_addr_0,
   input  wire logic [rbps_pkg::ADDR_WIDTH-1:0]       rsp_out_addr_1,
   input  wire logic [rbps_pkg::TOTAL_WIDTH-1:0]      rsp_total_0,
   input  wire logic                                  rsp_final_entry
);

   // Reset leaves no word on the output and room in the queue.
   `RBPS_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid && req_ready)

   // A stalled word holds its contents.
   `RBPS_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_addr_0) && $stable(rsp_total_0) && $stable(rsp_final_entry))

   // Column zero is always in use, so a closing word carries all ones there.
   `RBPS_ASSERT_IMP(a_closing_addr0, clock, reset, rsp_valid && rsp_final_entry, rsp_out_addr_0 == '1)

   // Closing column one is all ones when used and zero when not.
   `RBPS_ASSERT_IMP(a_closing_addr1, clock, reset, rsp_valid && rsp_final_entry, (rsp_out_addr_1 == '1) || (rsp_out_addr_1 == '0))

endmodule

bind run_boundary_prefix_sum rbps_checker u_checker (.*);

`default_nettype wire
